// ----- rtl/bpg_pkg.sv -----
// bpg_pkg: shared constants, register codes and helper functions for the
// bmp pixel to gray unit
// no dependencies
`default_nettype none

package bpg_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;

    localparam int PAL_AW      = $clog2(PALETTE_DEPTH);
    localparam int COUNT_W     = $clog2(MAX_WIDTH) + 1;
    localparam int POS_W       = 12;
    localparam int ROW_BYTES_W = 15;
    localparam int SUM_W       = 10;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // pixel formats
    localparam logic [2:0] FMT_PAL1   = 3'd0;
    localparam logic [2:0] FMT_PAL2   = 3'd1;
    localparam logic [2:0] FMT_PAL4   = 3'd2;
    localparam logic [2:0] FMT_PAL8   = 3'd3;
    localparam logic [2:0] FMT_BGR24  = 3'd4;
    localparam logic [2:0] FMT_BGRA32 = 3'd5;

    // item kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    // register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // color channel positions
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // floor(s / 3) for s up to 765, by reciprocal multiply
    function automatic logic [7:0] div3(input logic [SUM_W-1:0] s);
        logic [20:0] p;
        p = {11'b0, s} * 21'd683;
        return p[18:11];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bmp_pixel_to_gray_unit.sv -----
// bmp_pixel_to_gray_unit: uncompressed bmp pixel bytes in, gray pixels with
// column and row out, apb register port for format and image size
// depends on bpg_pkg
//
// usage
//   s_* stream: one item per transfer; s_tuser selects a palette entry load
//   (0) or a pixel data byte (1). load the palette before the pixel bytes.
//   m_* stream: one gray pixel per transfer, m_tlast on the last pixel of an
//   input byte, m_tuser on the final pixel of the image.
//   apb port: format at 0x0, width at 0x4, height at 0x8; write while idle.
// timing
//   a pixel passes the item register, the palette read request stage and the
//   output register on its way to m_*. pixels leave one per cycle while m_*
//   is not stalled; a byte gives up to 8, 4, 2 or 1 pixels in the 1, 2, 4 and
//   8 bit palette formats, one at a time through the single palette read port;
//   color bytes and palette loads leave the item register in one step.
// reset
//   clears the row and column position and sets 8-bit palette, 4096 x 4096;
//   palette contents are undefined until loaded.
// stall
//   a stalled m_* side holds its pixel; one more pixel waits in the stage behind it and then s_tready drops.
`default_nettype none

module bmp_pixel_to_gray_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // apb configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bpg_pkg::APB_AW-1:0]      paddr,
    input  wire logic [bpg_pkg::APB_DW-1:0]      pwdata,
    output logic      [bpg_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // data_byte[7:0], entry_index[15:8], blue[23:16], green[31:24], red[39:32]
    input  wire logic [bpg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  wire logic                            s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // gray[7:0], column[19:8], row[31:20]
    output logic      [bpg_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                 m_tlast,
    // frame_end[0]
    output logic                                 m_tuser
);

    // configuration registers
    logic [2:0]                      pixel_format_reg;
    logic [bpg_pkg::COUNT_W-1:0]     image_width_reg;
    logic [bpg_pkg::COUNT_W-1:0]     image_height_reg;

    // input item register
    logic                            busy_reg, busy_next;
    logic                            kind_reg, kind_next;
    logic [7:0]                      shift_reg, shift_next;
    logic [bpg_pkg::PAL_AW-1:0]      entry_reg, entry_next;
    logic [7:0]                      pal_gray_reg, pal_gray_next;
    logic [2:0]                      slot_reg, slot_next;

    // position state
    logic [bpg_pkg::COUNT_W-1:0]     column_reg, column_next;
    logic [bpg_pkg::ROW_BYTES_W-1:0] row_byte_reg, row_byte_next;
    logic [bpg_pkg::POS_W-1:0]       row_reg, row_next;
    logic [1:0]                      channel_reg, channel_next;
    logic [bpg_pkg::SUM_W-1:0]       color_sum_reg, color_sum_next;

    // palette read request stage
    logic                            p1_valid_reg, p1_valid_next;
    logic                            p1_pal_reg;
    logic [bpg_pkg::PAL_AW-1:0]      p1_idx_reg;
    logic [7:0]                      p1_gray_reg;
    logic [bpg_pkg::POS_W-1:0]       p1_column_reg;
    logic [bpg_pkg::POS_W-1:0]       p1_row_reg;
    logic                            p1_last_reg;
    logic                            p1_fe_reg;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic                            out_pal_reg;
    logic [7:0]                      out_gray_reg;
    logic [7:0]                      mem_q_reg;
    logic [bpg_pkg::POS_W-1:0]       out_column_reg;
    logic [bpg_pkg::POS_W-1:0]       out_row_reg;
    logic                            out_last_reg;
    logic                            out_fe_reg;

    logic [7:0] palette_mem [bpg_pkg::PALETTE_DEPTH];

    logic                            cfg_write;
    logic [bpg_pkg::COUNT_W-1:0]     eff_w;
    logic [bpg_pkg::COUNT_W-1:0]     eff_h;
    logic [bpg_pkg::ROW_BYTES_W-1:0] wz;
    logic [bpg_pkg::ROW_BYTES_W-1:0] row_bytes_raw;
    logic [bpg_pkg::ROW_BYTES_W-1:0] row_total;
    logic [bpg_pkg::ROW_BYTES_W-1:0] row_byte_inc;
    logic [bpg_pkg::COUNT_W-1:0]     col_plus;
    logic [bpg_pkg::COUNT_W-1:0]     row_plus;
    logic [bpg_pkg::SUM_W-1:0]       sum_now;
    logic [bpg_pkg::PAL_AW-1:0]      pix_idx;
    logic [7:0]                      shift_adv;
    logic                            palette_mode;
    logic                            color_mode;
    logic                            valid_fmt;
    logic                            col_in;
    logic                            last_slot;
    logic                            pix_last;
    logic                            frame_end;
    logic                            is_pal_load;
    logic                            emit;
    logic                            needs_p1;
    logic                            p1_take;
    logic                            step;
    logic                            step_final;
    logic                            accept;
    logic                            p1_load;
    logic                            out_load;
    logic                            p1_adv;
    logic                            pal_write;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= bpg_pkg::FMT_PAL8;
            image_width_reg  <= bpg_pkg::COUNT_W'(bpg_pkg::MAX_WIDTH);
            image_height_reg <= bpg_pkg::COUNT_W'(bpg_pkg::MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                bpg_pkg::REG_FORMAT: pixel_format_reg <= pwdata[2:0];
                bpg_pkg::REG_WIDTH:  image_width_reg  <= pwdata[bpg_pkg::COUNT_W-1:0];
                bpg_pkg::REG_HEIGHT: image_height_reg <= pwdata[bpg_pkg::COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bpg_pkg::REG_FORMAT: prdata = {29'b0, pixel_format_reg};
            bpg_pkg::REG_WIDTH:
                prdata = {{(bpg_pkg::APB_DW-bpg_pkg::COUNT_W){1'b0}}, image_width_reg};
            bpg_pkg::REG_HEIGHT:
                prdata = {{(bpg_pkg::APB_DW-bpg_pkg::COUNT_W){1'b0}}, image_height_reg};
            default:             prdata = '0;
        endcase
    end

    // clamped image size and row length in bytes
    always_comb
    begin
        if (image_width_reg == '0)
            eff_w = bpg_pkg::COUNT_W'(1);
        else if (image_width_reg > bpg_pkg::COUNT_W'(bpg_pkg::MAX_WIDTH))
            eff_w = bpg_pkg::COUNT_W'(bpg_pkg::MAX_WIDTH);
        else
            eff_w = image_width_reg;

        if (image_height_reg == '0)
            eff_h = bpg_pkg::COUNT_W'(1);
        else if (image_height_reg > bpg_pkg::COUNT_W'(bpg_pkg::MAX_HEIGHT))
            eff_h = bpg_pkg::COUNT_W'(bpg_pkg::MAX_HEIGHT);
        else
            eff_h = image_height_reg;

        wz = {2'b00, eff_w};
        case (pixel_format_reg)
            bpg_pkg::FMT_PAL1:   row_bytes_raw = (wz + 15'd7) >> 3;
            bpg_pkg::FMT_PAL2:   row_bytes_raw = (wz + 15'd3) >> 2;
            bpg_pkg::FMT_PAL4:   row_bytes_raw = (wz + 15'd1) >> 1;
            bpg_pkg::FMT_BGR24:  row_bytes_raw = (wz << 1) + wz;
            bpg_pkg::FMT_BGRA32: row_bytes_raw = wz << 2;
            default:             row_bytes_raw = wz;
        endcase
        row_total = (row_bytes_raw + 15'd3) & ~15'd3;
    end

    // unpacking of the current byte
    always_comb
    begin
        palette_mode = (pixel_format_reg <= bpg_pkg::FMT_PAL8);
        color_mode   = (pixel_format_reg == bpg_pkg::FMT_BGR24) ||
                       (pixel_format_reg == bpg_pkg::FMT_BGRA32);
        valid_fmt    = palette_mode || color_mode;
        col_in       = (column_reg < eff_w);
        col_plus     = column_reg + bpg_pkg::COUNT_W'(1);
        row_plus     = {1'b0, row_reg} + bpg_pkg::COUNT_W'(1);
        sum_now      = color_sum_reg + {2'b00, shift_reg};

        case (pixel_format_reg)
            bpg_pkg::FMT_PAL1:
            begin
                pix_idx   = {7'b0, shift_reg[7]};
                last_slot = (slot_reg == 3'd7);
                shift_adv = {shift_reg[6:0], 1'b0};
            end
            bpg_pkg::FMT_PAL2:
            begin
                pix_idx   = {6'b0, shift_reg[7:6]};
                last_slot = (slot_reg == 3'd3);
                shift_adv = {shift_reg[5:0], 2'b0};
            end
            bpg_pkg::FMT_PAL4:
            begin
                pix_idx   = {4'b0, shift_reg[7:4]};
                last_slot = (slot_reg == 3'd1);
                shift_adv = {shift_reg[3:0], 4'b0};
            end
            default:
            begin
                pix_idx   = shift_reg;
                last_slot = 1'b1;
                shift_adv = shift_reg;
            end
        endcase

        pix_last  = last_slot || (col_plus >= eff_w);
        frame_end = ({1'b0, row_reg} == (eff_h - bpg_pkg::COUNT_W'(1))) &&
                    (column_reg == (eff_w - bpg_pkg::COUNT_W'(1)));

        is_pal_load = (kind_reg == bpg_pkg::KIND_PALETTE);
        emit        = !is_pal_load && valid_fmt && col_in &&
                      (palette_mode || (channel_reg == bpg_pkg::CH_RED));
        needs_p1    = emit || is_pal_load;
        out_load    = !out_valid_reg || m_tready;
        p1_take     = !p1_valid_reg || out_load;
        step        = busy_reg && (!needs_p1 || p1_take);
        step_final  = is_pal_load || !palette_mode || !col_in || pix_last;
        s_tready    = !busy_reg || (step && step_final);
        accept      = s_tvalid && s_tready;
        p1_load     = step && emit;
        pal_write   = step && is_pal_load;
        p1_adv      = p1_valid_reg && out_load;
    end

    // item register next state
    always_comb
    begin
        busy_next     = busy_reg;
        kind_next     = kind_reg;
        shift_next    = shift_reg;
        entry_next    = entry_reg;
        pal_gray_next = pal_gray_reg;
        slot_next     = slot_reg;
        if (accept)
        begin
            busy_next     = 1'b1;
            kind_next     = s_tuser;
            shift_next    = s_tdata[7:0];
            entry_next    = s_tdata[15:8];
            pal_gray_next = bpg_pkg::div3({2'b00, s_tdata[23:16]} +
                                          {2'b00, s_tdata[31:24]} +
                                          {2'b00, s_tdata[39:32]});
            slot_next     = 3'd0;
        end
        else if (step && step_final)
        begin
            busy_next = 1'b0;
        end
        else if (step)
        begin
            shift_next = shift_adv;
            slot_next  = slot_reg + 3'd1;
        end
    end

    // position next state
    always_comb
    begin
        column_next    = column_reg;
        row_byte_next  = row_byte_reg;
        row_next       = row_reg;
        channel_next   = channel_reg;
        color_sum_next = color_sum_reg;
        row_byte_inc   = row_byte_reg + bpg_pkg::ROW_BYTES_W'(1);

        if (step && !is_pal_load && valid_fmt)
        begin
            if (col_in)
            begin
                if (palette_mode)
                begin
                    column_next = col_plus;
                end
                else
                begin
                    case (channel_reg)
                        bpg_pkg::CH_BLUE:
                        begin
                            color_sum_next = {2'b00, shift_reg};
                            channel_next   = bpg_pkg::CH_GREEN;
                        end
                        bpg_pkg::CH_GREEN:
                        begin
                            color_sum_next = sum_now;
                            channel_next   = bpg_pkg::CH_RED;
                        end
                        bpg_pkg::CH_RED:
                        begin
                            color_sum_next = sum_now;
                            column_next    = col_plus;
                            channel_next   = (pixel_format_reg == bpg_pkg::FMT_BGRA32) ?
                                             bpg_pkg::CH_ALPHA : bpg_pkg::CH_BLUE;
                        end
                        default:
                        begin
                            channel_next = bpg_pkg::CH_BLUE;
                        end
                    endcase
                end
            end

            if (step_final)
            begin
                if (row_byte_inc >= row_total)
                begin
                    row_byte_next = '0;
                    column_next   = '0;
                    channel_next  = bpg_pkg::CH_BLUE;
                    if (row_plus >= eff_h)
                        row_next = '0;
                    else
                        row_next = row_plus[bpg_pkg::POS_W-1:0];
                end
                else
                begin
                    row_byte_next = row_byte_inc;
                end
            end
        end
    end

    assign p1_valid_next  = p1_load || (p1_valid_reg && !out_load);
    assign out_valid_next = p1_adv || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            column_reg    <= '0;
            row_byte_reg  <= '0;
            row_reg       <= '0;
            channel_reg   <= bpg_pkg::CH_BLUE;
            color_sum_reg <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            column_reg    <= column_next;
            row_byte_reg  <= row_byte_next;
            row_reg       <= row_next;
            channel_reg   <= channel_next;
            color_sum_reg <= color_sum_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        shift_reg    <= shift_next;
        entry_reg    <= entry_next;
        pal_gray_reg <= pal_gray_next;
        slot_reg     <= slot_next;

        if (p1_load)
        begin
            p1_pal_reg    <= palette_mode;
            p1_idx_reg    <= pix_idx;
            p1_gray_reg   <= bpg_pkg::div3(sum_now);
            p1_column_reg <= column_reg[bpg_pkg::POS_W-1:0];
            p1_row_reg    <= row_reg;
            p1_last_reg   <= palette_mode ? pix_last : 1'b1;
            p1_fe_reg     <= frame_end;
        end

        if (p1_adv)
        begin
            out_pal_reg    <= p1_pal_reg;
            out_gray_reg   <= p1_gray_reg;
            out_column_reg <= p1_column_reg;
            out_row_reg    <= p1_row_reg;
            out_last_reg   <= p1_last_reg;
            out_fe_reg     <= p1_fe_reg;
        end
    end

    // palette store: read of older pixels sees the entry before a same-edge write
    always_ff @(posedge clk)
    begin
        if (pal_write)
            palette_mem[entry_reg] <= pal_gray_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p1_adv)
            mem_q_reg <= palette_mem[p1_idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_column_reg, out_pal_reg ? mem_q_reg : out_gray_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fe_reg;

endmodule

`default_nettype wire

// ----- bench/gray_pixel_checker.sv -----
`timescale 1ns / 1ps
// gray_pixel_checker: follows the register port and both streams of the bmp
// pixel to gray unit, predicts each gray pixel and compares it on transfer
// depends on bpg_pkg
module gray_pixel_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpg_pkg::APB_AW-1:0]      paddr,
    input  logic [bpg_pkg::APB_DW-1:0]      pwdata,
    input  logic                            pready,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bpg_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bpg_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    input  logic                            m_tuser,
    output int                              mismatch_count,
    output int                              pixels_pending
);

    typedef struct {
        logic [7:0]  gray;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        logic        frame_end;
    } gray_pixel_t;

    logic [7:0]  palette_gray [bpg_pkg::PALETTE_DEPTH];
    int unsigned col_cnt;
    int unsigned row_bytes;
    int unsigned row_cnt;
    int unsigned color_sum;
    logic [1:0]  chan;
    logic [2:0]  fmt;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    gray_pixel_t expected_pixels [$];

    function automatic int unsigned eff_width();
        if (width_reg < 1)
            return 1;
        if (width_reg > bpg_pkg::MAX_WIDTH)
            return bpg_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < 1)
            return 1;
        if (height_reg > bpg_pkg::MAX_HEIGHT)
            return bpg_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic int unsigned bits_per_pixel();
        case (fmt)
            bpg_pkg::FMT_PAL1:  return 1;
            bpg_pkg::FMT_PAL2:  return 2;
            bpg_pkg::FMT_PAL4:  return 4;
            bpg_pkg::FMT_PAL8:  return 8;
            bpg_pkg::FMT_BGR24: return 24;
            default:            return 32;
        endcase
    endfunction

    function automatic int unsigned row_total();
        int unsigned bytes;
        bytes = (eff_width() * bits_per_pixel() + 7) / 8;
        return (bytes + 3) & ~32'd3;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_pixel(input logic [7:0] gray, input logic last_flag);
        gray_pixel_t p;
        p.gray      = gray;
        p.column    = 12'(col_cnt);
        p.row       = 12'(row_cnt);
        p.last      = last_flag;
        p.frame_end = (row_cnt == eff_height() - 1) && (col_cnt == eff_width() - 1);
        expected_pixels.push_back(p);
    endtask

    task automatic predict_pixels(input logic kind, input logic [7:0] data_byte,
                                  input logic [7:0] entry, input logic [7:0] blue,
                                  input logic [7:0] green, input logic [7:0] red);
        int unsigned w;
        int unsigned bpp;
        int unsigned per;
        int unsigned idx;
        int unsigned byte_v;
        int unsigned i;
        byte_v = data_byte;
        if (kind == bpg_pkg::KIND_PALETTE)
        begin
            palette_gray[entry] = 8'((int'(blue) + int'(green) + int'(red)) / 3);
            return;
        end
        if (fmt > bpg_pkg::FMT_BGRA32)
            return;
        w = eff_width();
        if (col_cnt < w)
        begin
            if (fmt <= bpg_pkg::FMT_PAL8)
            begin
                bpp = bits_per_pixel();
                per = 8 / bpp;
                for (i = 0; i < per && col_cnt < w; i++)
                begin
                    idx = (byte_v >> (8 - bpp * (i + 1))) & ((1 << bpp) - 1);
                    push_pixel(palette_gray[idx], (i + 1 == per) || (col_cnt + 1 >= w));
                    col_cnt++;
                end
            end
            else
            begin
                case (chan)
                    bpg_pkg::CH_BLUE:
                    begin
                        color_sum = byte_v;
                        chan = bpg_pkg::CH_GREEN;
                    end
                    bpg_pkg::CH_GREEN:
                    begin
                        color_sum += byte_v;
                        chan = bpg_pkg::CH_RED;
                    end
                    bpg_pkg::CH_RED:
                    begin
                        color_sum += byte_v;
                        push_pixel(8'(color_sum / 3), 1'b1);
                        col_cnt++;
                        chan = (fmt == bpg_pkg::FMT_BGRA32) ? bpg_pkg::CH_ALPHA
                                                            : bpg_pkg::CH_BLUE;
                    end
                    default:
                        chan = bpg_pkg::CH_BLUE;
                endcase
            end
        end
        row_bytes++;
        if (row_bytes >= row_total())
        begin
            row_bytes = 0;
            col_cnt = 0;
            chan = bpg_pkg::CH_BLUE;
            if (row_cnt + 1 >= eff_height())
                row_cnt = 0;
            else
                row_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gray_pixel_t want;
        if (!rst_n)
        begin
            expected_pixels.delete();
            col_cnt        = 0;
            row_bytes      = 0;
            row_cnt        = 0;
            color_sum      = 0;
            chan           = bpg_pkg::CH_BLUE;
            fmt            = bpg_pkg::FMT_PAL8;
            width_reg      = 13'(bpg_pkg::MAX_WIDTH);
            height_reg     = 13'(bpg_pkg::MAX_HEIGHT);
            mismatch_count = 0;
            pixels_pending = 0;
        end
        else
        begin
            // outputs first: a pixel never leaves at the edge its byte arrives
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("pixel %h with nothing expected", m_tdata));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[7:0] !== want.gray)
                        report_mismatch($sformatf("gray got %h want %h",
                                                  m_tdata[7:0], want.gray));
                    if (m_tdata[19:8] !== want.column)
                        report_mismatch($sformatf("column got %0d want %0d",
                                                  m_tdata[19:8], want.column));
                    if (m_tdata[31:20] !== want.row)
                        report_mismatch($sformatf("row got %0d want %0d",
                                                  m_tdata[31:20], want.row));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast got %b want %b",
                                                  m_tlast, want.last));
                    if (m_tuser !== want.frame_end)
                        report_mismatch($sformatf("frame end got %b want %b",
                                                  m_tuser, want.frame_end));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[bpg_pkg::APB_AW-1:2])
                    bpg_pkg::REG_FORMAT: fmt        = pwdata[2:0];
                    bpg_pkg::REG_WIDTH:  width_reg  = pwdata[12:0];
                    bpg_pkg::REG_HEIGHT: height_reg = pwdata[12:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_pixels(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                               s_tdata[31:24], s_tdata[39:32]);
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// testbench: top of the bmp pixel to gray unit bench; drives register writes,
// palette and pixel byte transfers and output back-pressure, gives the verdict
// depends on bpg_pkg, bmp_pixel_to_gray_unit and gray_pixel_checker
module testbench;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 120;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bpg_pkg::APB_AW-1:0]      paddr;
    logic [bpg_pkg::APB_DW-1:0]      pwdata;
    logic [bpg_pkg::APB_DW-1:0]      prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bpg_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bpg_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;
    int                              mismatch_count;
    int                              pixels_pending;

    int tx_idle_pct = 11;
    int rx_idle_pct = 59;
    bit hold_req    = 1'b0;

    always #6 clk = ~clk;

    bmp_pixel_to_gray_unit dut (.*);

    gray_pixel_checker gray_check (.*);

    initial
    begin
        #5_000_000;
        $display("[bmp_pixel_to_gray_unit] ERROR");
        $finish;
    end

    // output side back-pressure, with one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic kind,
                             input logic [bpg_pkg::IN_TDATA_W-1:0] payload);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_pixel_byte(input logic [7:0] data_byte);
        send_item(bpg_pkg::KIND_PIXEL, {32'($urandom), data_byte});
    endtask

    // rgb packs red in the top byte and blue in the bottom byte
    task automatic send_palette_entry(input logic [7:0] entry, input logic [23:0] rgb);
        send_item(bpg_pkg::KIND_PALETTE, {rgb, entry, 8'($urandom)});
    endtask

    // quiet the input and let every pending pixel and stray byte drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pixels_pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int unsigned value);
        logic [bpg_pkg::APB_DW-1:0] keep;
        keep = (idx == bpg_pkg::REG_FORMAT) ? 32'h7 : 32'h1FFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~keep) | (value & keep);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] f, input int unsigned w, input int unsigned h);
        settle();
        write_register(bpg_pkg::REG_FORMAT, f);
        write_register(bpg_pkg::REG_WIDTH, w);
        write_register(bpg_pkg::REG_HEIGHT, h);
    endtask

    function automatic int row_span(input logic [2:0] f, input int w);
        int bits;
        if (w < 1)
            w = 1;
        else if (w > bpg_pkg::MAX_WIDTH)
            w = bpg_pkg::MAX_WIDTH;
        case (f)
            bpg_pkg::FMT_PAL1:  bits = 1;
            bpg_pkg::FMT_PAL2:  bits = 2;
            bpg_pkg::FMT_PAL4:  bits = 4;
            bpg_pkg::FMT_PAL8:  bits = 8;
            bpg_pkg::FMT_BGR24: bits = 24;
            default:            bits = 32;
        endcase
        return (((w * bits + 7) / 8 + 3) / 4) * 4;
    endfunction

    // in 8-bit palette mode keep to the loaded entries at either end
    function automatic logic [7:0] pixel_byte(input logic [2:0] f);
        logic [7:0] b;
        b = 8'($urandom);
        if (f == bpg_pkg::FMT_PAL8)
            b[6:4] = {3{b[7]}};
        return b;
    endfunction

    initial
    begin
        int          i;
        int          w;
        int          h;
        int          n;
        int          items_sent;
        logic [2:0]  f;
        logic [23:0] rgb;
        int          extremes [4];

        extremes = '{0, 1, bpg_pkg::MAX_WIDTH, 8191};
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = bpg_pkg::KIND_PIXEL;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lowest and highest 16 entries, black at the bottom and white at the top
        for (i = 0; i < 16; i++)
        begin
            rgb = (i == 0) ? 24'h000000 : 24'($urandom);
            send_palette_entry(8'(i), rgb);
            rgb = (i == 0) ? 24'hFFFFFF : 24'($urandom);
            send_palette_entry(8'(bpg_pkg::PALETTE_DEPTH - 1 - i), rgb);
        end

        // reset setting: 8-bit palette, full size
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hFF);

        // clamped size, the half-done row closes at the new row length
        configure(bpg_pkg::FMT_PAL2, 0, 8191);
        repeat (2) send_pixel_byte(8'($urandom));
        send_pixel_byte(8'hE4);
        repeat (3) send_pixel_byte(8'($urandom));

        // row number already past the new height
        configure(bpg_pkg::FMT_PAL1, 10, 1);
        send_pixel_byte(8'hA5);
        send_pixel_byte(8'h5A);
        repeat (2) send_pixel_byte(8'($urandom));

        configure(bpg_pkg::FMT_PAL4, 3, 1);
        send_pixel_byte(8'h0F);
        send_pixel_byte(8'hF0);
        repeat (2) send_pixel_byte(8'($urandom));

        // 32-bit pixel, then 24-bit with the alpha slot still pending
        configure(bpg_pkg::FMT_BGRA32, 2, 1);
        repeat (3) send_pixel_byte(8'h00);
        settle();
        write_register(bpg_pkg::REG_FORMAT, bpg_pkg::FMT_BGR24);
        send_pixel_byte(8'($urandom));
        repeat (3) send_pixel_byte(8'hFF);
        send_pixel_byte(8'($urandom));

        // unused formats
        settle();
        write_register(bpg_pkg::REG_FORMAT, bpg_pkg::FMT_BGRA32 + 1);
        send_pixel_byte(8'($urandom));
        settle();
        write_register(bpg_pkg::REG_FORMAT, bpg_pkg::FMT_BGRA32 + 2);
        send_pixel_byte(8'($urandom));

        // long output hold-off while the input keeps offering bytes
        configure(bpg_pkg::FMT_PAL1, 64, 4);
        hold_req = 1'b1;
        repeat (24) send_pixel_byte(8'($urandom));

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 11;
                rx_idle_pct = 59;
            end
            else if (items_sent < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 59;
                rx_idle_pct = 11;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if ($urandom_range(19) == 0)
                f = 3'(bpg_pkg::FMT_BGRA32 + $urandom_range(2, 1));
            else
                f = 3'($urandom_range(bpg_pkg::FMT_BGRA32, bpg_pkg::FMT_PAL1));
            w = ($urandom_range(9) == 0) ? extremes[$urandom_range(3)] : $urandom_range(24, 1);
            h = ($urandom_range(9) == 0) ? extremes[$urandom_range(3)] : $urandom_range(4, 1);
            configure(f, w, h);
            if (f > bpg_pkg::FMT_BGRA32)
            begin
                n = $urandom_range(3, 1);
                repeat (n) send_pixel_byte(8'($urandom));
                items_sent += n;
                continue;
            end
            n = row_span(f, w) * $urandom_range(3, 1);
            if (n > 48)
                n = $urandom_range(48, 8);
            // some runs stop short of the row end
            if ($urandom_range(6) == 0)
                n = $urandom_range(n, 1);
            repeat (n)
            begin
                if ($urandom_range(11) == 0)
                begin
                    send_palette_entry(8'($urandom), 24'($urandom));
                    items_sent++;
                end
                send_pixel_byte(pixel_byte(f));
                items_sent++;
            end
        end

        settle();
        @(negedge clk);
        if (mismatch_count == 0)
            $display("[bmp_pixel_to_gray_unit] OK");
        else
            $display("[bmp_pixel_to_gray_unit] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bpg_pkg.sv
rtl/bmp_pixel_to_gray_unit.sv
bench/gray_pixel_checker.sv
bench/testbench.sv
